/* rtl/delay_line_pitch_shifter_unit_assert.svh */
// Assertion macros shared by the pitch shifter RTL.
// Each macro takes a label, the clock, the active-low reset,
// an antecedent, a consequent and a message string.
`ifndef DELAY_LINE_PITCH_SHIFTER_UNIT_ASSERT_SVH
`define DELAY_LINE_PITCH_SHIFTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define DLPS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define DLPS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define DLPS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define DLPS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

/* rtl/dlps_pkg.sv */
`timescale 1ns / 1ps

package dlps_pkg;

  // Fixed field widths
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned INC_W     = 18;
  localparam int unsigned WIN_W     = 11;
  // Window is Q1.10; the ramp scale is 2048 / DEPTH
  localparam int unsigned WIN_FRAC  = 10;
  localparam int unsigned WIN_SHIFT = 11;

  localparam logic [INC_W-1:0] INC_RESET = 18'd98193;

  // Operation of the shared multiplier
  typedef enum logic [1:0] {
    OP_NONE,
    OP_LERP,
    OP_WEIGHT
  } mac_op_e;

  // Sequencer to arithmetic unit controls
  typedef struct packed {
    logic    cur_ld;
    mac_op_e op;
    logic    acc_clr;
    logic    acc_add;
  } mac_ctl_t;

endpackage

/* rtl/dlps_store.sv */
`timescale 1ns / 1ps

module dlps_store #(
  parameter int unsigned DEPTH = 2048
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              re_i,
  input  logic [$clog2(DEPTH)-1:0]          raddr_i,
  input  logic                              we_i,
  input  logic signed [dlps_pkg::SAMPLE_W-1:0] wdata_i,
  output logic signed [dlps_pkg::SAMPLE_W-1:0] rdata_o,
  output logic [$clog2(DEPTH)-1:0]          wr_idx_o
);
  import dlps_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic signed [SAMPLE_W-1:0] mem_q [DEPTH];
  logic signed [SAMPLE_W-1:0] rd_raw_q;
  logic                       rd_valid_q;
  logic [AW-1:0]              wr_idx_q;
  logic                       full_q;

  // Sample memory: one read port with registered data, one write port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_raw_q <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[wr_idx_q] <= wdata_i;
    end
  end

  // Fill tracking: writes go in order, so an entry holds data once the
  // write index has passed it or the memory has wrapped once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q   <= '0;
      full_q     <= 1'b0;
      rd_valid_q <= 1'b0;
    end else begin
      if (re_i) begin
        rd_valid_q <= full_q || (raddr_i < wr_idx_q);
      end
      if (we_i) begin
        wr_idx_q <= wr_idx_q + AW'(1);
        if (wr_idx_q == LAST) begin
          full_q <= 1'b1;
        end
      end
    end
  end

  // Unwritten entries read as zero
  assign rdata_o  = rd_valid_q ? rd_raw_q : '0;
  assign wr_idx_o = wr_idx_q;

endmodule

/* rtl/dlps_mac.sv */
`timescale 1ns / 1ps

module dlps_mac #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  dlps_pkg::mac_ctl_t                   ctl_i,
  input  logic signed [dlps_pkg::SAMPLE_W-1:0] rdata_i,
  input  logic [FRAC_BITS-1:0]                 frac_i,
  input  logic [dlps_pkg::WIN_W-1:0]           win_i,
  input  logic signed [dlps_pkg::SAMPLE_W-1:0] dry_i,
  output logic signed [dlps_pkg::SAMPLE_W-1:0] sum_o
);
  import dlps_pkg::*;

  // Difference / interpolated sample width
  localparam int unsigned DW  = SAMPLE_W + 1;
  // Unsigned multiplier operand width
  localparam int unsigned MB  = (FRAC_BITS > WIN_W) ? FRAC_BITS : WIN_W;
  localparam int unsigned PRW = DW + MB + 1;
  localparam int unsigned ACW = SAMPLE_W + 2;

  localparam logic [PRW-1:0] LERP_RND   = PRW'((1 << FRAC_BITS) - 1);
  localparam logic [PRW-1:0] WEIGHT_RND = PRW'((1 << WIN_FRAC) - 1);

  logic signed [SAMPLE_W-1:0] cur_q;
  logic signed [PRW-1:0]      prod_q;
  logic signed [PRW-1:0]      prod_d;
  logic signed [ACW-1:0]      acc_q;

  logic signed [DW-1:0]  mul_a;
  logic [MB-1:0]         mul_b;
  logic signed [MB:0]    mul_bs;
  logic signed [PRW-1:0] lerp_bias;
  logic signed [PRW-1:0] lerp_sh;
  logic signed [PRW-1:0] wt_bias;
  logic signed [PRW-1:0] wt_sh;
  logic signed [DW-1:0]  interp;

  // Truncate toward zero: bias negative products before the shift
  assign lerp_bias = prod_q + (prod_q[PRW-1] ? LERP_RND : '0);
  assign lerp_sh   = lerp_bias >>> FRAC_BITS;
  assign wt_bias   = prod_q + (prod_q[PRW-1] ? WEIGHT_RND : '0);
  assign wt_sh     = wt_bias >>> WIN_FRAC;

  // Interpolated tap: cur + (nxt - cur) * frac
  assign interp = {cur_q[SAMPLE_W-1], cur_q} + lerp_sh[DW-1:0];

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl_i.op)
      OP_LERP: begin
        mul_a = {rdata_i[SAMPLE_W-1], rdata_i} - {cur_q[SAMPLE_W-1], cur_q};
        mul_b = MB'(frac_i);
      end
      OP_WEIGHT: begin
        mul_a = interp;
        mul_b = MB'(win_i);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_bs = {1'b0, mul_b};
  assign prod_d = mul_a * mul_bs;

  // Operand and product registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.cur_ld) begin
      cur_q <= rdata_i;
    end
    if (ctl_i.op != OP_NONE) begin
      prod_q <= prod_d;
    end
  end

  // Accumulator: starts at the dry sample, adds each weighted tap
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctl_i.acc_clr) begin
      acc_q <= {{(ACW - SAMPLE_W){dry_i[SAMPLE_W-1]}}, dry_i};
    end else if (ctl_i.acc_add) begin
      acc_q <= acc_q + {wt_sh[DW-1], wt_sh[DW-1:0]};
    end
  end

  // Saturate to the sample range
  always_comb begin
    if (!acc_q[ACW-1] && (acc_q[ACW-2:SAMPLE_W-1] != '0)) begin
      sum_o = {1'b0, {(SAMPLE_W - 1){1'b1}}};
    end else if (acc_q[ACW-1] && (acc_q[ACW-2:SAMPLE_W-1] != '1)) begin
      sum_o = {1'b1, {(SAMPLE_W - 1){1'b0}}};
    end else begin
      sum_o = acc_q[SAMPLE_W-1:0];
    end
  end

endmodule

/* rtl/dlps_ctrl.sv */
`timescale 1ns / 1ps
`include "delay_line_pitch_shifter_unit_assert.svh"

module dlps_ctrl #(
  parameter int unsigned DEPTH     = 2048,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          out_free_i,
  output logic                          out_load_o,
  input  logic                          cfg_we_i,
  input  logic [dlps_pkg::INC_W-1:0]    cfg_wdata_i,
  input  logic [$clog2(DEPTH)-1:0]      wr_idx_i,
  output logic                          store_re_o,
  output logic [$clog2(DEPTH)-1:0]      store_raddr_o,
  output logic                          store_we_o,
  output dlps_pkg::mac_ctl_t            mac_ctl_o,
  output logic [FRAC_BITS-1:0]          frac_o,
  output logic [dlps_pkg::WIN_W-1:0]    win_o
);
  import dlps_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PW = AW + FRAC_BITS;
  localparam int unsigned SW = ((PW > INC_W) ? PW : INC_W) + 1;

  localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);
  localparam logic [AW-1:0] HALF    = AW'(DEPTH / 2);
  localparam logic [AW-1:0] HALF_M1 = AW'(DEPTH / 2 - 1);
  localparam logic [SW-1:0] POS_LIMIT = SW'(DEPTH) << FRAC_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_NXT,
    S_LERP,
    S_WEIGHT,
    S_ACC,
    S_DONE
  } state_e;

  state_e           state_q, state_d;
  logic             tap_q, tap_d;
  logic [PW-1:0]    pos_q, pos_d;
  logic [INC_W-1:0] inc_q;

  logic          accept;
  logic [AW-1:0] ip1;
  logic [AW-1:0] ip2;
  logic [AW-1:0] ip_cur;
  logic [SW-1:0] pos_sum;

  // Triangular crossfade window, Q1.10
  function automatic logic [WIN_W-1:0] win_at(input logic [AW-1:0] k);
    logic [AW-1:0]           x;
    logic [AW+WIN_SHIFT-1:0] xs;
    begin
      x  = (k < HALF_M1) ? k : (LAST - k);
      xs = {x, {WIN_SHIFT{1'b0}}} >> AW;
      return xs[WIN_W-1:0];
    end
  endfunction

  // Ready only between requests
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Tap positions; the second tap sits half the store ahead
  assign ip1    = pos_q[PW-1:FRAC_BITS];
  assign ip2    = ip1 + HALF;
  assign ip_cur = tap_q ? ip2 : ip1;
  assign frac_o = pos_q[FRAC_BITS-1:0];
  assign win_o  = win_at(ip_cur - wr_idx_i);

  // Read position advance, cleared on reaching the end of the store
  assign pos_sum = SW'(pos_q) + SW'(inc_q);

  // Sequencer outputs
  always_comb begin
    store_re_o    = 1'b0;
    store_raddr_o = ip_cur;
    store_we_o    = 1'b0;
    out_load_o    = 1'b0;
    mac_ctl_o     = '{cur_ld: 1'b0, op: OP_NONE, acc_clr: 1'b0, acc_add: 1'b0};
    case (state_q)
      S_IDLE: begin
        store_re_o        = accept;
        store_raddr_o     = ip1;
        mac_ctl_o.acc_clr = accept;
      end
      S_RD_NXT: begin
        store_re_o       = 1'b1;
        store_raddr_o    = ip_cur + AW'(1);
        mac_ctl_o.cur_ld = 1'b1;
      end
      S_LERP: begin
        mac_ctl_o.op = OP_LERP;
      end
      S_WEIGHT: begin
        mac_ctl_o.op = OP_WEIGHT;
      end
      S_ACC: begin
        mac_ctl_o.acc_add = 1'b1;
        store_re_o        = !tap_q;
        store_raddr_o     = ip2;
      end
      S_DONE: begin
        store_we_o = out_free_i;
        out_load_o = out_free_i;
      end
      default: begin
        store_re_o = 1'b0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    tap_d   = tap_q;
    pos_d   = pos_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_RD_NXT;
          tap_d   = 1'b0;
        end
      end
      S_RD_NXT: state_d = S_LERP;
      S_LERP:   state_d = S_WEIGHT;
      S_WEIGHT: state_d = S_ACC;
      S_ACC: begin
        if (tap_q) begin
          state_d = S_DONE;
        end else begin
          state_d = S_RD_NXT;
          tap_d   = 1'b1;
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          state_d = S_IDLE;
          pos_d   = (pos_sum >= POS_LIMIT) ? '0 : pos_sum[PW-1:0];
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State, read position and pitch increment register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tap_q   <= 1'b0;
      pos_q   <= '0;
      inc_q   <= INC_RESET;
    end else begin
      state_q <= state_d;
      tap_q   <= tap_d;
      pos_q   <= pos_d;
      if (cfg_we_i) begin
        inc_q <= cfg_wdata_i;
      end
    end
  end

  `DLPS_ASSERT_IMP(a_no_write_when_ready, clk_i, rst_ni, in_ready_o, !store_we_o, "store written while taking a request")
  `DLPS_ASSERT_NXT(a_accept_starts_tap, clk_i, rst_ni, accept, (state_q == S_RD_NXT) && !tap_q, "request did not start first tap")
  `DLPS_ASSERT_IMP(a_load_needs_room, clk_i, rst_ni, out_load_o, out_free_i, "result loaded over a pending result")
  `DLPS_ASSERT_NXT(a_second_tap, clk_i, rst_ni, (state_q == S_ACC) && !tap_q, tap_q && (state_q == S_RD_NXT), "second tap not started")

endmodule

/* rtl/delay_line_pitch_shifter_unit.sv */
`timescale 1ns / 1ps
// sample_out_o is registered; a new request is taken only once the result of the
// last one is loaded, which waits while results are not taken; per request the one
// shared multiplier runs four times and the store's single read port four times.
// Reset clears write index, read position and the store fill tracking (unwritten
// entries read as zero) and loads pitch increment 98193. DEPTH is a power of two.
module delay_line_pitch_shifter_unit #(
  parameter int unsigned DEPTH     = 2048,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [dlps_pkg::SAMPLE_W-1:0] sample_in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [dlps_pkg::SAMPLE_W-1:0] sample_out_o,
  input  logic                                 cfg_we_i,
  input  logic [dlps_pkg::INC_W-1:0]           cfg_wdata_i
);
  import dlps_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] sample_out_q;
  logic signed [SAMPLE_W-1:0] dry_q;

  logic                       out_free;
  logic                       out_load;
  logic                       store_re;
  logic [AW-1:0]              store_raddr;
  logic                       store_we;
  logic signed [SAMPLE_W-1:0] store_rdata;
  logic [AW-1:0]              wr_idx;
  mac_ctl_t                   mac_ctl;
  logic [FRAC_BITS-1:0]       frac;
  logic [WIN_W-1:0]           win;
  logic signed [SAMPLE_W-1:0] wet_sum;

  assign out_free = !out_valid_q || out_ready_i;

  dlps_ctrl #(
    .DEPTH     (DEPTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .out_free_i    (out_free),
    .out_load_o    (out_load),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .wr_idx_i      (wr_idx),
    .store_re_o    (store_re),
    .store_raddr_o (store_raddr),
    .store_we_o    (store_we),
    .mac_ctl_o     (mac_ctl),
    .frac_o        (frac),
    .win_o         (win)
  );

  dlps_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .re_i     (store_re),
    .raddr_i  (store_raddr),
    .we_i     (store_we),
    .wdata_i  (dry_q),
    .rdata_o  (store_rdata),
    .wr_idx_o (wr_idx)
  );

  dlps_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (mac_ctl),
    .rdata_i (store_rdata),
    .frac_i  (frac),
    .win_i   (win),
    .dry_i   (sample_in_i),
    .sum_o   (wet_sum)
  );

  // Hold the dry sample for the store write at the end of the request
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      dry_q <= sample_in_i;
    end
    if (out_load) begin
      sample_out_q <= wet_sum;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import dlps_pkg::*;

  localparam int unsigned DEPTH      = 2048;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned CYCLE_CAP  = 2_000_000;
  localparam int unsigned DRAIN_WAIT = 20;

  typedef enum int {
    MIX_FULL,
    MIX_RAIL,
    MIX_HUSH,
    MIX_RAMP
  } sample_mix_e;

  // Tracks the delay store, both taps and the output queue of the shifter
  class pitch_shift_scoreboard;
    logic signed [SAMPLE_W-1:0] delay_store [DEPTH];
    int unsigned                write_ptr;
    longint unsigned            read_pos;
    logic [INC_W-1:0]           step;
    logic signed [SAMPLE_W-1:0] expected_out [$];
    int unsigned                errors;

    function new();
      foreach (delay_store[i]) delay_store[i] = '0;
      write_ptr = 0;
      read_pos  = 0;
      step      = INC_RESET;
      errors    = 0;
    endfunction

    function void set_increment(logic [INC_W-1:0] v);
      step = v;
    endfunction

    function int unsigned pending();
      return expected_out.size();
    endfunction

    // Triangular crossfade gain, Q1.10
    function longint fade_gain(int unsigned k);
      longint unsigned x;
      x = (k < DEPTH / 2 - 1) ? k : DEPTH - 1 - k;
      return longint'((x * 2048) / DEPTH);
    endfunction

    // One interpolated, windowed tap; divisions truncate toward zero
    function longint tap_out(int unsigned ipos, longint frac);
      int unsigned nidx;
      int unsigned widx;
      longint      cur;
      longint      nxt;
      longint      interp;
      nidx   = (ipos + 1 >= DEPTH) ? 0 : ipos + 1;
      cur    = delay_store[ipos];
      nxt    = delay_store[nidx];
      interp = cur + ((nxt - cur) * frac) / (longint'(1) << FRAC_BITS);
      widx   = (ipos >= write_ptr) ? ipos - write_ptr : ipos + DEPTH - write_ptr;
      return (interp * fade_gain(widx)) / 1024;
    endfunction

    // Predict the output for an accepted sample, then advance the state
    function void note_sample(logic signed [SAMPLE_W-1:0] s);
      int unsigned                ip1;
      int unsigned                ip2;
      longint                     frac;
      longint                     total;
      logic signed [SAMPLE_W-1:0] y;
      ip1  = int'(read_pos >> FRAC_BITS);
      frac = longint'(read_pos & ((64'd1 << FRAC_BITS) - 1));
      ip2  = ip1 + DEPTH / 2;
      if (ip2 >= DEPTH) ip2 -= DEPTH;
      total = tap_out(ip1, frac) + tap_out(ip2, frac) + longint'(s);
      if (total > 32767) total = 32767;
      if (total < -32768) total = -32768;
      y = total[SAMPLE_W-1:0];
      expected_out.push_back(y);
      delay_store[write_ptr] = s;
      write_ptr = (write_ptr + 1) % DEPTH;
      read_pos += step;
      if (read_pos >= (64'(DEPTH) << FRAC_BITS)) read_pos = 0;
    endfunction

    function void check_sample(logic signed [SAMPLE_W-1:0] actual);
      logic signed [SAMPLE_W-1:0] exp_val;
      if (expected_out.size() == 0) begin
        $display("%0t: sample_out %0d with no request pending", $time, actual);
        errors++;
      end else begin
        exp_val = expected_out.pop_front();
        if (exp_val !== actual) begin
          $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                   $time, exp_val, actual);
          errors++;
        end
      end
    endfunction
  endclass

  logic                       clk_i;
  logic                       rst_ni       = 1'b0;
  logic                       in_valid_i   = 1'b0;
  logic                       in_ready_o;
  logic signed [SAMPLE_W-1:0] sample_in_i  = '0;
  logic                       out_valid_o;
  logic                       out_ready_i  = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out_o;
  logic                       cfg_we_i     = 1'b0;
  logic [INC_W-1:0]           cfg_wdata_i  = '0;

  pitch_shift_scoreboard sb;
  bit                    quiet_phase = 1'b0;
  int unsigned           cycle_count = 0;
  int unsigned           out_stall   = 0;
  int                    ramp_level  = 0;

  delay_line_pitch_shifter_unit #(
    .DEPTH    (DEPTH),
    .FRAC_BITS(FRAC_BITS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_in_i (sample_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sample_out_o(sample_out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Result side: random back-pressure
  always @(posedge clk_i) begin
    if (out_stall != 0) begin
      out_ready_i <= 1'b0;
      out_stall   = out_stall - 1;
    end else begin
      out_ready_i <= 1'b1;
      if (!quiet_phase && $urandom_range(0, 3) == 0) out_stall = pick_gap();
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_sample(sample_out_o);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_CAP) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Present one request and hold it until taken
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    int unsigned gap;
    in_valid_i  <= 1'b1;
    sample_in_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(s);
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    while (sb.pending() != 0 || !in_ready_o) @(posedge clk_i);
  endtask

  // Register write only with nothing in flight
  task automatic write_increment(input logic [INC_W-1:0] v);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.set_increment(v);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] make_sample(sample_mix_e mix);
    int v;
    case (mix)
      MIX_RAIL: begin
        v = $urandom_range(0, 1) ? 32767 - $urandom_range(0, 3)
                                 : -32768 + $urandom_range(0, 3);
      end
      MIX_HUSH: begin
        v = $urandom_range(0, 128) - 64;
      end
      MIX_RAMP: begin
        ramp_level = ramp_level + $urandom_range(0, 4096) - 2048;
        if (ramp_level > 32767) ramp_level = -32768;
        if (ramp_level < -32768) ramp_level = 32767;
        v = ramp_level;
      end
      default: begin
        v = $urandom;
      end
    endcase
    return v[SAMPLE_W-1:0];
  endfunction

  // Bursts of one signal character each
  task automatic send_random(input int unsigned count);
    int unsigned left;
    int unsigned burst;
    int unsigned r;
    sample_mix_e mix;
    left = count;
    while (left != 0) begin
      r = $urandom_range(0, 99);
      if (r < 40) mix = MIX_FULL;
      else if (r < 65) mix = MIX_RAIL;
      else if (r < 85) mix = MIX_HUSH;
      else mix = MIX_RAMP;
      burst = $urandom_range(4, 40);
      if (burst > left) burst = left;
      repeat (burst) send_sample(make_sample(mix));
      left -= burst;
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: sample extremes under the reset increment
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'shffff);
    send_sample(16'sh0001);
    send_sample(16'sh5555);
    send_sample(16'shaaaa);
    repeat (4) send_sample(16'sh7fff);
    repeat (4) send_sample(16'sh8000);
    send_random(170);

    // Frozen read position
    write_increment('0);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_random(150);

    // Largest step: fast wraps of the read position
    write_increment({INC_W{1'b1}});
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_random(250);

    // Unity step, no idling on either side
    quiet_phase = 1'b1;
    write_increment(18'd65536);
    send_random(150);
    quiet_phase = 1'b0;

    // Smallest nonzero step: slow fraction sweep
    write_increment(18'd1);
    send_random(100);

    // Arbitrary steps
    repeat (3) begin
      write_increment(INC_W'($urandom));
      send_random(120);
    end

    // Drain and finish
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
